// ===== hdl/gld_pkg.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared types, widths and codes for the LZW decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gld_pkg;

  // Dictionary size and derived widths.
  localparam int unsigned MaxCodes  = 4096;
  localparam int unsigned CodeW     = $clog2(MaxCodes);
  localparam int unsigned CountW    = CodeW + 1;
  localparam int unsigned PixW      = 24;
  localparam int unsigned BufW      = 24;
  localparam int unsigned BitCntW   = 5;
  localparam int unsigned MaxCodeLen = 12;

  // Configuration register indexes.
  localparam logic CFG_MIN_CODE_SIZE = 1'b0;
  localparam logic CFG_FRAME_PIXELS  = 1'b1;

  // Input word action codes.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_END   = 2'd2,
    ACT_PULL  = 2'd3
  } action_e;

  // Status codes reported with every result word.
  localparam logic [2:0] STAT_DECODING = 3'd0;
  localparam logic [2:0] STAT_END_CODE = 3'd1;
  localparam logic [2:0] STAT_EXHAUST  = 3'd2;
  localparam logic [2:0] STAT_INVALID  = 3'd3;
  localparam logic [2:0] STAT_BAD      = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/gld_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/gif_lzw_decoder.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Byte-wise LZW decompression of a GIF image data stream into palette indices.
// ----------------------------------------------------------------------------
// Each input word is a start, a byte push, an end of data or a pixel pull, and
// each gives exactly one result word. Start, push, end and a pull that finds
// the frame complete or decoding stopped answer straight from S_IDLE. A pull
// that pops a stacked character passes through S_POP_RD and S_POP_WR. A pull
// that must decode a new code goes to S_FETCH and reads codes (clear codes
// included), walks each string character through the prefix and suffix
// memories in S_WALK and S_WALK_WR, as their single registered read port
// needs, pushes the string's root character in S_WALK, then takes the two pop
// states. A pull that runs short of bits or stops during the code read answers
// right after the codes it read. The block takes one word at a time and
// accepts the next once the result register is empty. No clearing pass runs
// after reset: the memories are only read where decoding wrote them.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  data_byte_i,
  // Output channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             byte_taken_o,
  output logic             pixel_valid_o,
  output logic [7:0]       pixel_index_o,
  output logic             last_pixel_o,
  output logic             need_byte_o,
  output logic [2:0]       status_o
);

  localparam int unsigned CW = gld_pkg::CodeW;
  localparam int unsigned NW = gld_pkg::CountW;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FETCH   = 6'b000010,
    S_WALK    = 6'b000100,
    S_WALK_WR = 6'b001000,
    S_POP_RD  = 6'b010000,
    S_POP_WR  = 6'b100000
  } state_e;

  state_e st_q, st_d;

  logic [3:0]                  mcs_q, mcs_d;
  logic [gld_pkg::PixW-1:0]    fpix_q, fpix_d;
  logic [3:0]                  lat_mcs_q, lat_mcs_d;
  logic [gld_pkg::PixW-1:0]    lat_pix_q, lat_pix_d;
  logic [NW-1:0]               cnt_q, cnt_d;
  logic [gld_pkg::BufW-1:0]    buf_q, buf_d;
  logic [gld_pkg::BitCntW-1:0] bcnt_q, bcnt_d;
  logic [3:0]                  cw_q, cw_d;
  logic [NW-1:0]               nfc_q, nfc_d;
  logic [CW-1:0]               prev_q, prev_d;
  logic                        prev_vld_q, prev_vld_d;
  logic [7:0]                  first_q, first_d;
  logic [gld_pkg::PixW-1:0]    given_q, given_d;
  logic                        ended_q, ended_d;
  logic [2:0]                  stop_q, stop_d;
  logic                        any_q, any_d;
  logic [CW-1:0]               c_q, c_d;
  logic [CW-1:0]               code_q, code_d;

  logic       ov_q, ov_d;
  logic       taken_q, taken_d;
  logic       pvld_q, pvld_d;
  logic [7:0] pix_q, pix_d;
  logic       last_q, last_d;
  logic       need_q, need_d;
  logic [2:0] stat_q, stat_d;

  // Memory ports.
  logic          stk_we;
  logic [CW-1:0] stk_waddr;
  logic [7:0]    stk_wdata;
  logic [7:0]    stk_rdata;
  logic [NW-1:0] stk_top;
  logic          tab_we;
  logic [CW-1:0] pre_rdata;
  logic [7:0]    suf_rdata;

  // Decode helpers.
  logic [NW-1:0]            clr;
  logic [NW-1:0]            eoi;
  logic [gld_pkg::BufW-1:0] code_mask;
  logic [CW-1:0]            code;
  logic [NW-1:0]            code_x;
  logic [NW-1:0]            nfc_inc;
  logic                     bad_mcs;
  logic                     accept;
  logic [gld_pkg::PixW-1:0] given_inc;

  assign clr       = NW'(1) << lat_mcs_q;
  assign eoi       = clr + NW'(1);
  assign code_mask = (gld_pkg::BufW'(1) << cw_q) - gld_pkg::BufW'(1);
  assign code      = CW'(buf_q & code_mask);
  assign code_x    = {1'b0, code};
  assign nfc_inc   = nfc_q + NW'(1);
  assign bad_mcs   = (mcs_q < 4'd2) || (mcs_q > 4'd11);
  assign accept    = in_valid_i && in_ready_o;
  assign given_inc = given_q + gld_pkg::PixW'(1);
  assign stk_top   = cnt_q - NW'(1);
  assign stk_waddr = cnt_q[CW-1:0];
  assign tab_we    = (st_q == S_WALK) && !(({1'b0, c_q} > eoi) &&
                     (cnt_q < NW'(gld_pkg::MaxCodes - 1))) &&
                     prev_vld_q && (nfc_q < NW'(gld_pkg::MaxCodes));

  assign in_ready_o = (st_q == S_IDLE) && !ov_q;

  // Sequencer and next-state logic.
  always_comb begin
    st_d       = st_q;
    mcs_d      = mcs_q;
    fpix_d     = fpix_q;
    lat_mcs_d  = lat_mcs_q;
    lat_pix_d  = lat_pix_q;
    cnt_d      = cnt_q;
    buf_d      = buf_q;
    bcnt_d     = bcnt_q;
    cw_d       = cw_q;
    nfc_d      = nfc_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    first_d    = first_q;
    given_d    = given_q;
    ended_d    = ended_q;
    stop_d     = stop_q;
    any_d      = any_q;
    c_d        = c_q;
    code_d     = code_q;
    ov_d       = ov_q && !out_ready_i;
    taken_d    = taken_q;
    pvld_d     = pvld_q;
    pix_d      = pix_q;
    last_d     = last_q;
    need_d     = need_q;
    stat_d     = stat_q;
    stk_we     = 1'b0;
    stk_wdata  = c_q[7:0];

    // Configuration writes.
    if (cfg_we_i) begin
      if (cfg_idx_i == gld_pkg::CFG_MIN_CODE_SIZE) begin
        mcs_d = cfg_data_i[3:0];
      end else begin
        fpix_d = cfg_data_i;
      end
    end

    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          ov_d    = 1'b1;
          taken_d = 1'b0;
          pvld_d  = 1'b0;
          pix_d   = 8'd0;
          last_d  = 1'b0;
          need_d  = 1'b0;
          stat_d  = stop_q;
          case (gld_pkg::action_e'(action_i))
            gld_pkg::ACT_START: begin
              lat_mcs_d  = mcs_q;
              lat_pix_d  = fpix_q;
              cnt_d      = '0;
              buf_d      = '0;
              bcnt_d     = '0;
              first_d    = '0;
              given_d    = '0;
              ended_d    = 1'b0;
              any_d      = 1'b0;
              cw_d       = mcs_q + 4'd1;
              prev_vld_d = 1'b0;
              prev_d     = '0;
              stop_d     = bad_mcs ? gld_pkg::STAT_BAD : gld_pkg::STAT_DECODING;
              nfc_d      = bad_mcs ? '0 : (NW'(1) << mcs_q) + NW'(2);
              stat_d     = stop_d;
            end
            gld_pkg::ACT_PUSH: begin
              if (!ended_q && stop_q == gld_pkg::STAT_DECODING &&
                  bcnt_q <= gld_pkg::BitCntW'(16)) begin
                buf_d   = buf_q | (gld_pkg::BufW'(data_byte_i) << bcnt_q);
                bcnt_d  = bcnt_q + gld_pkg::BitCntW'(8);
                any_d   = 1'b1;
                taken_d = 1'b1;
              end
            end
            gld_pkg::ACT_END: begin
              if (!ended_q && !any_q && stop_q == gld_pkg::STAT_DECODING) begin
                stop_d = gld_pkg::STAT_BAD;
                stat_d = gld_pkg::STAT_BAD;
              end
              ended_d = 1'b1;
            end
            default: begin
              if (given_q < lat_pix_q) begin
                if (stop_q != gld_pkg::STAT_DECODING) begin
                  pvld_d  = 1'b1;
                  given_d = given_inc;
                  last_d  = (given_inc == lat_pix_q);
                end else if (cnt_q == '0) begin
                  ov_d = 1'b0;
                  st_d = S_FETCH;
                end else begin
                  ov_d = 1'b0;
                  st_d = S_POP_RD;
                end
              end
            end
          endcase
        end
      end

      // Read one code; clear codes loop here.
      S_FETCH: begin
        if ({1'b0, bcnt_q} < {1'b0, cw_q}) begin
          ov_d   = 1'b1;
          taken_d = 1'b0;
          pix_d  = 8'd0;
          st_d   = S_IDLE;
          if (!ended_q) begin
            pvld_d = 1'b0;
            last_d = 1'b0;
            need_d = 1'b1;
            stat_d = stop_q;
          end else begin
            stop_d  = any_q ? gld_pkg::STAT_EXHAUST : gld_pkg::STAT_BAD;
            stat_d  = stop_d;
            pvld_d  = 1'b1;
            need_d  = 1'b0;
            given_d = given_inc;
            last_d  = (given_inc == lat_pix_q);
          end
        end else begin
          buf_d  = buf_q >> cw_q;
          bcnt_d = bcnt_q - gld_pkg::BitCntW'(cw_q);
          code_d = code;
          if (code_x == clr) begin
            cw_d       = lat_mcs_q + 4'd1;
            nfc_d      = clr + NW'(2);
            prev_vld_d = 1'b0;
            prev_d     = '0;
          end else if (code_x == eoi || code_x > nfc_q ||
                       (code_x == nfc_q && !prev_vld_q)) begin
            stop_d  = (code_x == eoi) ? gld_pkg::STAT_END_CODE : gld_pkg::STAT_INVALID;
            ov_d    = 1'b1;
            taken_d = 1'b0;
            pvld_d  = 1'b1;
            pix_d   = 8'd0;
            need_d  = 1'b0;
            stat_d  = stop_d;
            given_d = given_inc;
            last_d  = (given_inc == lat_pix_q);
            st_d    = S_IDLE;
          end else begin
            if (code_x == nfc_q) begin
              stk_we    = 1'b1;
              stk_wdata = first_q;
              cnt_d     = cnt_q + NW'(1);
              c_d       = prev_q;
            end else begin
              c_d = code;
            end
            st_d = S_WALK;
          end
        end
      end

      // Walk the chain, or finish the string and extend the dictionary.
      S_WALK: begin
        if (({1'b0, c_q} > eoi) && (cnt_q < NW'(gld_pkg::MaxCodes - 1))) begin
          st_d = S_WALK_WR;
        end else begin
          stk_we     = 1'b1;
          stk_wdata  = c_q[7:0];
          cnt_d      = cnt_q + NW'(1);
          first_d    = c_q[7:0];
          if (tab_we) begin
            nfc_d = nfc_inc;
            if (nfc_inc == (NW'(1) << cw_q) && cw_q < 4'(gld_pkg::MaxCodeLen)) begin
              cw_d = cw_q + 4'd1;
            end
          end
          prev_d     = code_q;
          prev_vld_d = 1'b1;
          st_d       = S_POP_RD;
        end
      end

      S_WALK_WR: begin
        stk_we    = 1'b1;
        stk_wdata = suf_rdata;
        cnt_d     = cnt_q + NW'(1);
        c_d       = pre_rdata;
        st_d      = S_WALK;
      end

      S_POP_RD: begin
        cnt_d = stk_top;
        st_d  = S_POP_WR;
      end

      S_POP_WR: begin
        ov_d    = 1'b1;
        taken_d = 1'b0;
        pvld_d  = 1'b1;
        pix_d   = stk_rdata;
        need_d  = 1'b0;
        stat_d  = stop_q;
        given_d = given_inc;
        last_d  = (given_inc == lat_pix_q);
        st_d    = S_IDLE;
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      mcs_q      <= 4'd8;
      fpix_q     <= '0;
      lat_mcs_q  <= 4'd8;
      lat_pix_q  <= '0;
      cnt_q      <= '0;
      buf_q      <= '0;
      bcnt_q     <= '0;
      cw_q       <= 4'd9;
      nfc_q      <= NW'(258);
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
      first_q    <= '0;
      given_q    <= '0;
      ended_q    <= 1'b0;
      stop_q     <= gld_pkg::STAT_DECODING;
      any_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      st_q       <= st_d;
      mcs_q      <= mcs_d;
      fpix_q     <= fpix_d;
      lat_mcs_q  <= lat_mcs_d;
      lat_pix_q  <= lat_pix_d;
      cnt_q      <= cnt_d;
      buf_q      <= buf_d;
      bcnt_q     <= bcnt_d;
      cw_q       <= cw_d;
      nfc_q      <= nfc_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
      first_q    <= first_d;
      given_q    <= given_d;
      ended_q    <= ended_d;
      stop_q     <= stop_d;
      any_q      <= any_d;
      ov_q       <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    code_q  <= code_d;
    taken_q <= taken_d;
    pvld_q  <= pvld_d;
    pix_q   <= pix_d;
    last_q  <= last_d;
    need_q  <= need_d;
    stat_q  <= stat_d;
  end

  // String stack and dictionary memories.
  gld_ram #(.Width(8), .Depth(gld_pkg::MaxCodes)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_top[CW-1:0]),
    .rdata_o (stk_rdata)
  );

  gld_ram #(.Width(CW), .Depth(gld_pkg::MaxCodes)) u_prefix (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (nfc_q[CW-1:0]),
    .wdata_i (prev_q),
    .raddr_i (c_q),
    .rdata_o (pre_rdata)
  );

  gld_ram #(.Width(8), .Depth(gld_pkg::MaxCodes)) u_suffix (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (nfc_q[CW-1:0]),
    .wdata_i (c_q[7:0]),
    .raddr_i (c_q),
    .rdata_o (suf_rdata)
  );

  assign out_valid_o   = ov_q;
  assign byte_taken_o  = taken_q;
  assign pixel_valid_o = pvld_q;
  assign pixel_index_o = pix_q;
  assign last_pixel_o  = last_q;
  assign need_byte_o   = need_q;
  assign status_o      = stat_q;

endmodule

`default_nettype wire

// ===== hdl/gld_checker.sv =====
// ----------------------------------------------------------------------------
// GIF LZW decoder checker
// Port-level assertions on the result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gld_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       byte_taken_o,
  input wire logic       pixel_valid_o,
  input wire logic       last_pixel_o,
  input wire logic       need_byte_o,
  input wire logic [2:0] status_o
);

  // A stalled result word stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A word never both gives a pixel and asks for data.
  a_need_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pixel_valid_o && need_byte_o))
    else $error("pixel and need_byte together");

  // The last-pixel mark only rides on a given pixel.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> pixel_valid_o)
    else $error("last_pixel without pixel");

  // Bytes are taken and data requested only while still decoding.
  a_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_taken_o || need_byte_o) |->
      status_o == gld_pkg::STAT_DECODING)
    else $error("byte flow while stopped");

endmodule

bind gif_lzw_decoder gld_checker u_gld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .byte_taken_o  (byte_taken_o),
  .pixel_valid_o (pixel_valid_o),
  .last_pixel_o  (last_pixel_o),
  .need_byte_o   (need_byte_o),
  .status_o      (status_o)
);

`default_nettype wire
